// File: hw/rtl/wfc_pkg.sv
// Shared constants and types for the word frequency counter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package wfc_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int WORD_BYTES    = 16;
    localparam int KEEP_BYTES    = WORD_BYTES - 1;

    // Derived widths
    localparam int SLOT_W    = $clog2(TABLE_ENTRIES);
    localparam int DIST_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W     = $clog2(KEEP_BYTES + 1);
    localparam int TOK_IDX_W = (KEEP_BYTES > 1) ? $clog2(KEEP_BYTES) : 1;
    localparam int COUNT_W   = 16;
    localparam int BYTE_W    = 8;

    // Delimiter and letter codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One table row: saturating count, stored length, truncated text
    typedef struct packed {
        logic [COUNT_W-1:0]                count;
        logic [LEN_W-1:0]                  len;
        logic [KEEP_BYTES-1:0][BYTE_W-1:0] text;
    } wfc_row_t;

    // Controller to datapath
    typedef struct packed {
        logic ready;    // input channel may take a request
        logic take;     // request accepted this cycle
        logic scan;     // step the table walk
        logic hit_wr;   // bump count of matched entry
        logic miss_wr;  // append entry or flag overflow
        logic emit;     // load the result register
    } wfc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic word_end;  // accepted byte closes a non-empty token
        logic last;      // current request ends the sentence
        logic hit;
        logic miss;
        logic out_free;  // result register can be loaded
    } wfc_sts_t;

endpackage

// File: hw/rtl/wfc_if.sv
// Valid/ready channel interfaces for byte requests and counter results.
// Depends on wfc_pkg for field widths.
interface wfc_byte_if;
    import wfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_sentence;

    modport source (output valid, output byte_in, output end_of_sentence, input ready);
    modport sink   (input valid, input byte_in, input end_of_sentence, output ready);
endinterface

interface wfc_result_if;
    import wfc_pkg::*;

    logic               valid;
    logic               ready;
    logic               word_done;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] occurrences;
    logic               new_word;
    logic               sentence_done;
    logic [DIST_W-1:0]  distinct_total;
    logic               overflow_error;

    modport source (output valid, output word_done, output slot, output occurrences,
                    output new_word, output sentence_done, output distinct_total,
                    output overflow_error, input ready);
    modport sink   (input valid, input word_done, input slot, input occurrences,
                    input new_word, input sentence_done, input distinct_total,
                    input overflow_error, output ready);
endinterface

// File: hw/rtl/wfc_ctrl.sv
// Sequencer for the word frequency counter: take a byte, walk the table, emit.
// Depends on wfc_pkg for the command and status structs.
module wfc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  wfc_pkg::wfc_sts_t sts,
    output wfc_pkg::wfc_cmd_t cmd
);
    import wfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.word_end)
                        state_next = S_SCAN;
                    else if (sts.last)
                        state_next = S_EMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    cmd.hit_wr = 1'b1;
                    state_next = S_EMIT;
                end
                else if (sts.miss)
                begin
                    cmd.miss_wr = 1'b1;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: hw/rtl/wfc_datapath.sv
// Datapath: token buffer, word table memory, compare unit and result register.
// Depends on wfc_pkg and the channel interfaces in wfc_if.sv.
module wfc_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    wfc_byte_if.sink          byte_stream,
    wfc_result_if.source      result,
    input  wfc_pkg::wfc_cmd_t cmd,
    output wfc_pkg::wfc_sts_t sts
);
    import wfc_pkg::*;

    // Word table
    wfc_row_t row_mem [TABLE_ENTRIES];
    wfc_row_t row_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    wfc_row_t          mem_wd;
    logic              mem_re;

    // Token and sentence state
    logic [KEEP_BYTES-1:0][BYTE_W-1:0] tok_text_reg;
    logic [LEN_W-1:0]  tok_len_reg;
    logic [DIST_W-1:0] used_reg;
    logic              err_reg;
    logic              last_reg;

    // Walk state
    logic [DIST_W-1:0] idx_reg;
    logic              cmp_valid_reg;
    logic [SLOT_W-1:0] cmp_slot_reg;

    // Pending result fields
    logic               res_done_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [COUNT_W-1:0] res_cnt_reg;
    logic               res_new_reg;
    logic               res_ovf_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_done_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [COUNT_W-1:0] out_cnt_reg;
    logic               out_new_reg;
    logic               out_last_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_ovf_reg;

    logic              in_delim;
    logic              in_append;
    logic [BYTE_W-1:0] in_lower;
    logic              text_eq;
    logic              hit;
    logic              miss;
    logic              table_full;
    logic [COUNT_W-1:0] hit_cnt;

    // Byte classification
    assign in_delim  = (byte_stream.byte_in == CH_NUL) || (byte_stream.byte_in == CH_TAB) ||
                       (byte_stream.byte_in == CH_NL)  || (byte_stream.byte_in == CH_SPACE);
    assign in_lower  = ((byte_stream.byte_in >= CH_UP_A) && (byte_stream.byte_in <= CH_UP_Z))
                       ? (byte_stream.byte_in | CASE_BIT) : byte_stream.byte_in;
    assign in_append = !err_reg && !in_delim && (tok_len_reg < LEN_W'(KEEP_BYTES));

    // Masked compare of the stored row against the token
    always_comb
    begin
        text_eq = 1'b1;
        for (int i = 0; i < KEEP_BYTES; i++)
        begin
            if ((LEN_W'(i) < tok_len_reg) && (row_reg.text[i] != tok_text_reg[i]))
                text_eq = 1'b0;
        end
    end

    assign hit        = cmp_valid_reg && (row_reg.len == tok_len_reg) && text_eq;
    assign miss       = !hit && (idx_reg >= used_reg);
    assign table_full = (used_reg >= DIST_W'(TABLE_ENTRIES));
    assign hit_cnt    = (row_reg.count == COUNT_MAX) ? COUNT_MAX : row_reg.count + COUNT_W'(1);

    // Status to controller
    always_comb
    begin
        sts.in_valid = byte_stream.valid;
        sts.word_end = !err_reg && (in_delim || byte_stream.end_of_sentence) &&
                       ((tok_len_reg != '0) || in_append);
        sts.last     = byte_stream.end_of_sentence;
        sts.hit      = hit;
        sts.miss     = miss;
        sts.out_free = !out_valid_reg || result.ready;
    end

    assign byte_stream.ready = cmd.ready;

    // Table write and read port controls
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cmp_slot_reg;
        mem_wd = row_reg;
        if (cmd.hit_wr)
        begin
            mem_we       = 1'b1;
            mem_wd.count = hit_cnt;
        end
        else if (cmd.miss_wr && !table_full)
        begin
            mem_we       = 1'b1;
            mem_wa       = used_reg[SLOT_W-1:0];
            mem_wd.count = COUNT_W'(1);
            mem_wd.len   = tok_len_reg;
            mem_wd.text  = tok_text_reg;
        end
    end

    // No read in the cycle that writes back a hit
    assign mem_re = cmd.scan && !hit && (idx_reg < used_reg);

    // Table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            row_mem[mem_wa] <= mem_wd;
        if (mem_re)
            row_reg <= row_mem[idx_reg[SLOT_W-1:0]];
    end

    // Token text bytes
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_append)
            tok_text_reg[tok_len_reg[TOK_IDX_W-1:0]] <= in_lower;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_len_reg   <= '0;
            used_reg      <= '0;
            err_reg       <= 1'b0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                last_reg      <= byte_stream.end_of_sentence;
                idx_reg       <= '0;
                cmp_valid_reg <= 1'b0;
                if (in_append)
                    tok_len_reg <= tok_len_reg + LEN_W'(1);
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= mem_re;
                if (mem_re)
                    idx_reg <= idx_reg + DIST_W'(1);
            end

            if (cmd.hit_wr || cmd.miss_wr)
                tok_len_reg <= '0;
            if (cmd.miss_wr)
            begin
                if (table_full)
                    err_reg <= 1'b1;
                else
                    used_reg <= used_reg + DIST_W'(1);
            end

            // Result register handshake; sentence state clears after the final result
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    used_reg    <= '0;
                    tok_len_reg <= '0;
                    err_reg     <= 1'b0;
                end
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Walk slot and pending result fields
    always_ff @(posedge clk)
    begin
        if (mem_re)
            cmp_slot_reg <= idx_reg[SLOT_W-1:0];
        if (cmd.take)
        begin
            res_done_reg <= 1'b0;
            res_slot_reg <= '0;
            res_cnt_reg  <= '0;
            res_new_reg  <= 1'b0;
            res_ovf_reg  <= 1'b0;
        end
        else if (cmd.hit_wr)
        begin
            res_done_reg <= 1'b1;
            res_slot_reg <= cmp_slot_reg;
            res_cnt_reg  <= hit_cnt;
        end
        else if (cmd.miss_wr)
        begin
            if (table_full)
                res_ovf_reg <= 1'b1;
            else
            begin
                res_done_reg <= 1'b1;
                res_slot_reg <= used_reg[SLOT_W-1:0];
                res_cnt_reg  <= COUNT_W'(1);
                res_new_reg  <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_done_reg <= res_done_reg;
            out_slot_reg <= res_slot_reg;
            out_cnt_reg  <= res_cnt_reg;
            out_new_reg  <= res_new_reg;
            out_last_reg <= last_reg;
            out_dist_reg <= used_reg;
            out_ovf_reg  <= res_ovf_reg || (last_reg && err_reg);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.word_done      = out_done_reg;
    assign result.slot           = out_slot_reg;
    assign result.occurrences    = out_cnt_reg;
    assign result.new_word       = out_new_reg;
    assign result.sentence_done  = out_last_reg;
    assign result.distinct_total = out_dist_reg;
    assign result.overflow_error = out_ovf_reg;

endmodule

// File: hw/rtl/word_frequency_counter_core.sv
// Word frequency counter. Takes one sentence byte per request; space, tab, newline
// and zero end a token, A-Z are folded to lowercase and a token keeps its first 15
// bytes. Each finished token is looked up in a 64-entry table held in a single-port
// memory and walked one entry per cycle until a hit or the end of the stored
// entries. Any other byte is simply taken, and the final byte of a sentence also
// loads the result register. One request
// is in flight at a time. A result is produced when a word is counted, when the
// table overflows, and on the final byte, which also reports the distinct total
// and clears the table. After overflow the rest of the sentence is ignored.
module word_frequency_counter_core
(
    input  logic         clk,
    input  logic         rst_n,
    wfc_byte_if.sink     byte_stream,
    wfc_result_if.source result
);
    import wfc_pkg::*;

    wfc_cmd_t cmd;
    wfc_sts_t sts;

    wfc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    wfc_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .result      (result),
        .cmd         (cmd),
        .sts         (sts)
    );

    // Result register is only loaded when free
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over a pending result");

    // A lookup resolves as hit or miss, never both
    a_one_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.hit_wr && cmd.miss_wr))
        else $error("hit and miss in the same cycle");

    // A counted word and an overflow never share a result
    a_done_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.word_done && result.overflow_error))
        else $error("word counted on overflow");

    // A new entry always reports count one
    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.new_word) |->
            (result.word_done && result.occurrences == COUNT_W'(1)))
        else $error("new word without count of one");

endmodule

// File: sim/word_count_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the word frequency counter core: watches the byte and result
// channels, predicts every result from the accepted requests and compares fields.
// Depends on wfc_pkg and the channel interfaces in wfc_if.sv.
module word_count_checker
(
    input  logic  clk,
    input  logic  rst_n,
    wfc_byte_if   byte_mon,
    wfc_result_if res_mon,
    output int    pending,
    output int    mismatch_count,
    output int    request_count,
    output int    result_count,
    output int    new_word_count,
    output int    overflow_count,
    output int    saturated_count
);
    import wfc_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic               word_done;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] occurrences;
        logic               new_word;
        logic               sentence_done;
        logic [DIST_W-1:0]  distinct_total;
        logic               overflow_error;
    } word_result_t;

    word_result_t expected_q[$];

    // Shadow of the word table and the token being collected
    logic [BYTE_W-1:0]  word_text  [TABLE_ENTRIES][KEEP_BYTES];
    int unsigned        word_len   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] word_tally [TABLE_ENTRIES];
    int unsigned        words_used;
    logic [BYTE_W-1:0]  token_text [KEEP_BYTES];
    int unsigned        token_len;
    bit                 table_overflowed;

    int mismatches;
    int requests;
    int results;
    int new_words;
    int overflows;
    int saturations;

    initial
    begin
        mismatches  = 0;
        requests    = 0;
        results     = 0;
        new_words   = 0;
        overflows   = 0;
        saturations = 0;
    end

    // Apply one sentence byte; returns 1 when the byte produces a result
    function automatic bit count_byte(input logic [BYTE_W-1:0] raw, input logic closing,
                                      output word_result_t res);
        logic [BYTE_W-1:0] b;
        bit                emit;
        bit                delim;
        bit                same;
        int                found;
        int                i;
        int                j;

        res  = '0;
        emit = 1'b0;
        b    = raw;
        if (!table_overflowed)
        begin
            delim = (b == CH_NUL) || (b == CH_TAB) || (b == CH_NL) || (b == CH_SPACE);
            // fold A-Z, keep only the first KEEP_BYTES bytes of a token
            if (!delim && token_len < KEEP_BYTES)
            begin
                if (b >= CH_UP_A && b <= CH_UP_Z)
                    b = b | CASE_BIT;
                token_text[token_len] = b;
                token_len++;
            end
            if ((delim || closing) && token_len > 0)
            begin
                emit  = 1'b1;
                found = -1;
                for (i = 0; i < int'(words_used) && found < 0; i++)
                begin
                    if (word_len[i] == token_len)
                    begin
                        same = 1'b1;
                        for (j = 0; j < int'(token_len); j++)
                            if (word_text[i][j] != token_text[j])
                                same = 1'b0;
                        if (same)
                            found = i;
                    end
                end
                if (found >= 0)
                begin
                    // saturating count
                    if (word_tally[found] != COUNT_MAX)
                        word_tally[found]++;
                    res.word_done   = 1'b1;
                    res.slot        = SLOT_W'(found);
                    res.occurrences = word_tally[found];
                end
                else if (words_used < TABLE_ENTRIES)
                begin
                    for (j = 0; j < int'(token_len); j++)
                        word_text[words_used][j] = token_text[j];
                    word_len[words_used]   = token_len;
                    word_tally[words_used] = COUNT_W'(1);
                    res.word_done   = 1'b1;
                    res.slot        = SLOT_W'(words_used);
                    res.occurrences = COUNT_W'(1);
                    res.new_word    = 1'b1;
                    words_used++;
                end
                else
                begin
                    table_overflowed   = 1'b1;
                    res.overflow_error = 1'b1;
                end
                token_len = 0;
            end
        end
        if (closing)
        begin
            emit = 1'b1;
            if (table_overflowed)
                res.overflow_error = 1'b1;
        end
        res.sentence_done  = closing;
        res.distinct_total = DIST_W'(words_used);
        // sentence end clears table, token and error flag
        if (closing)
        begin
            words_used       = 0;
            token_len        = 0;
            table_overflowed = 1'b0;
        end
        return emit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin : monitor
        word_result_t want;
        if (!rst_n)
        begin
            words_used       = 0;
            token_len        = 0;
            table_overflowed = 1'b0;
            expected_q.delete();
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
            begin
                requests++;
                if (count_byte(byte_mon.byte_in, byte_mon.end_of_sentence, want))
                    expected_q.push_back(want);
            end
            if (res_mon.valid && res_mon.ready)
            begin
                results++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $error("result arrived with no result expected");
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("word_done", 32'(want.word_done), 32'(res_mon.word_done));
                    check_field("slot", 32'(want.slot), 32'(res_mon.slot));
                    check_field("occurrences", 32'(want.occurrences),
                                32'(res_mon.occurrences));
                    check_field("new_word", 32'(want.new_word), 32'(res_mon.new_word));
                    check_field("sentence_done", 32'(want.sentence_done),
                                32'(res_mon.sentence_done));
                    check_field("distinct_total", 32'(want.distinct_total),
                                32'(res_mon.distinct_total));
                    check_field("overflow_error", 32'(want.overflow_error),
                                32'(res_mon.overflow_error));
                    if (want.new_word)
                        new_words++;
                    if (want.overflow_error)
                        overflows++;
                    if (want.word_done && want.occurrences == COUNT_MAX)
                        saturations++;
                end
            end
        end
        pending         <= expected_q.size();
        mismatch_count  <= mismatches;
        request_count   <= requests;
        result_count    <= results;
        new_word_count  <= new_words;
        overflow_count  <= overflows;
        saturated_count <= saturations;
    end

endmodule

// File: sim/word_frequency_counter_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for word_frequency_counter_core: drives sentence bytes and result
// back-pressure and gives the verdict. Depends on wfc_pkg, wfc_if.sv and the
// scoreboard in word_count_checker.sv.
module word_frequency_counter_core_tb;
    import wfc_pkg::*;

    typedef logic [BYTE_W-1:0] text_t[$];

    localparam int                RANDOM_ITEMS   = 700;
    localparam int                VOCAB_SIZE     = 6;
    localparam int                RX_HOLD_CYCLES = 300;
    localparam int                DRAIN_CYCLES   = 100;
    localparam longint            TIMEOUT_NS     = 60_000_000;
    localparam logic [BYTE_W-1:0] CH_LOW_A       = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_Z       = 8'h7A;

    logic clk;
    logic rst_n;

    wfc_byte_if   byte_ch ();
    wfc_result_if res_ch ();

    // stimulus controls
    bit tx_quiet;
    bit rx_steady;
    int rx_holds_asked;
    int sent_count;
    int ignored_count;

    // scoreboard status
    int pending;
    int mismatch_count;
    int request_count;
    int result_count;
    int new_word_count;
    int overflow_count;
    int saturated_count;

    word_frequency_counter_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_ch),
        .result      (res_ch)
    );

    word_count_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_mon        (byte_ch),
        .res_mon         (res_ch),
        .pending         (pending),
        .mismatch_count  (mismatch_count),
        .request_count   (request_count),
        .result_count    (result_count),
        .new_word_count  (new_word_count),
        .overflow_count  (overflow_count),
        .saturated_count (saturated_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("word_frequency_counter_core_tb NOT OK");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_delim();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_NL;
            default: return CH_NUL;
        endcase
    endfunction

    // Any byte that is not a delimiter, letters of either case most often
    function automatic logic [BYTE_W-1:0] rand_token_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 9) < 7)
            return ($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + BYTE_W'($urandom_range(0, 25));
        do
            b = BYTE_W'($urandom_range(1, 255));
        while (b == CH_TAB || b == CH_NL || b == CH_SPACE);
        return b;
    endfunction

    function automatic text_t rand_word(input int len);
        text_t w;
        repeat (len) w.push_back(rand_token_byte());
        return w;
    endfunction

    // Word k of a table fill: two letters from k keep the words distinct
    function automatic text_t indexed_word(input int k);
        text_t w;
        w.push_back(($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + BYTE_W'(k / 26));
        w.push_back(($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + BYTE_W'(k % 26));
        repeat ($urandom_range(0, 2)) w.push_back(rand_token_byte());
        return w;
    endfunction

    // One request; valid stays high when the next one follows without a gap
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic closing);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid           <= 1'b1;
        byte_ch.byte_in         <= b;
        byte_ch.end_of_sentence <= closing;
        do
            @(posedge clk);
        while (byte_ch.ready !== 1'b1);
        sent_count++;
    endtask

    task automatic send_text(input text_t w, input logic closing);
        int i;
        for (i = 0; i < w.size(); i++)
            send_byte(w[i], closing && (i == w.size() - 1));
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Sentence drawn from a small vocabulary so that words repeat
    task automatic word_sentence();
        text_t vocab [VOCAB_SIZE];
        text_t w;
        int    n_words;
        int    k;
        int    i;
        bit    closing;
        for (k = 0; k < VOCAB_SIZE; k++)
            vocab[k] = rand_word($urandom_range(0, 4) == 0 ?
                                 $urandom_range(7, KEEP_BYTES + 5) : $urandom_range(1, 6));
        // same word with every letter's case flipped
        vocab[1] = vocab[0];
        for (i = 0; i < vocab[1].size(); i++)
            if ((vocab[1][i] >= CH_UP_A && vocab[1][i] <= CH_UP_Z) ||
                (vocab[1][i] >= CH_LOW_A && vocab[1][i] <= CH_LOW_Z))
                vocab[1][i] = vocab[1][i] ^ CASE_BIT;
        // two long words that differ only past the kept bytes
        vocab[2] = rand_word($urandom_range(KEEP_BYTES + 1, KEEP_BYTES + 5));
        vocab[3] = vocab[2];
        for (i = KEEP_BYTES; i < vocab[3].size(); i++)
            vocab[3][i] = rand_token_byte();
        n_words = $urandom_range(0, 12);
        closing = 1'b0;
        for (k = 0; k < n_words && !closing; k++)
        begin
            w       = vocab[$urandom_range(0, VOCAB_SIZE - 1)];
            closing = (k == n_words - 1) && ($urandom_range(0, 2) == 0);
            send_text(w, closing);
            if (!closing)
                repeat ($urandom_range(1, 2)) send_byte(rand_delim(), 1'b0);
        end
        if (!closing)
            send_byte($urandom_range(0, 1) ? rand_delim() : rand_token_byte(), 1'b1);
    endtask

    // Random bytes and delimiters
    task automatic noise_sentence();
        int n;
        int k;
        n = $urandom_range(1, 24);
        for (k = 0; k < n; k++)
            send_byte($urandom_range(0, 1) ? rand_delim() : BYTE_W'($urandom_range(0, 255)),
                      k == n - 1);
    endtask

    // Fill the table with n_words distinct words; one more than it holds overflows
    task automatic table_sentence(input int n_words);
        text_t seen [TABLE_ENTRIES + 1];
        int    k;
        for (k = 0; k < n_words; k++)
        begin
            seen[k] = indexed_word(k);
            send_text(seen[k], 1'b0);
            send_byte(rand_delim(), 1'b0);
            if (k < TABLE_ENTRIES && $urandom_range(0, 3) == 0)
            begin
                send_text(seen[$urandom_range(0, k)], 1'b0);
                send_byte(rand_delim(), 1'b0);
            end
        end
        if (n_words > TABLE_ENTRIES)
        begin
            // after the overflow the rest of the sentence is dropped
            repeat ($urandom_range(2, 12))
            begin
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                ignored_count++;
            end
            send_byte(rand_token_byte(), 1'b1);
        end
        else
        begin
            send_text(seen[$urandom_range(0, n_words - 1)], 1'b1);
        end
    endtask

    // Result side: random stalls, quiet stretches and the long hold-offs
    initial
    begin : result_sink
        int rx_gap;
        int quiet_left;
        int holds_served;
        rx_gap       = 0;
        quiet_left   = 0;
        holds_served = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != rx_holds_asked)
            begin
                res_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                holds_served++;
            end
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 199) == 0)
                quiet_left = $urandom_range(20, 200);
            if (rx_gap > 0 && !rx_steady)
            begin
                res_ch.ready <= 1'b0;
                rx_gap--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                rx_gap = (rx_steady || quiet_left > 0) ? 0 : pick_gap();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int  k;
        int  kind;
        int  random_start;
        bit  mid_hold;
        byte_ch.valid           = 1'b0;
        byte_ch.byte_in         = CH_NUL;
        byte_ch.end_of_sentence = 1'b0;
        tx_quiet                = 1'b0;
        rx_steady               = 1'b0;
        rx_holds_asked          = 0;
        sent_count              = 0;
        ignored_count           = 0;
        mid_hold                = 1'b0;
        rst_n                   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // case folding, a repeat, a high byte, an empty token, zero as delimiter,
        // and a word that ends on the final byte
        send_byte(CH_UP_A, 1'b0);
        send_byte(CH_UP_Z, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(CH_LOW_A, 1'b0);
        send_byte(CH_LOW_Z, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_LOW_A + 8'd16, 1'b1);
        // token longer than the kept bytes, closed by the final delimiter
        for (k = 0; k < KEEP_BYTES + 1; k++)
            send_byte(CH_UP_A + BYTE_W'(k), 1'b0);
        send_byte(CH_NUL, 1'b1);

        // long result stall while requests keep coming, then pause until drained
        rx_holds_asked <= rx_holds_asked + 1;
        tx_quiet = 1'b1;
        word_sentence();
        wait_drained();

        random_start = sent_count;
        tx_quiet = ($urandom_range(0, 1) == 0);
        table_sentence(TABLE_ENTRIES);
        tx_quiet = ($urandom_range(0, 1) == 0);
        table_sentence(TABLE_ENTRIES + 1);
        while (sent_count - ignored_count - random_start < RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            if (!mid_hold && sent_count - ignored_count - random_start > RANDOM_ITEMS / 2)
            begin
                mid_hold = 1'b1;
                rx_holds_asked <= rx_holds_asked + 1;
            end
            kind = $urandom_range(0, 19);
            if (kind < 15)
                word_sentence();
            else if (kind < 18)
                noise_sentence();
            else
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d requests, %0d results (%0d new words, %0d overflows, %0d saturated).",
                 request_count, result_count, new_word_count, overflow_count, saturated_count);
        $display("Covered case folding, long tokens, full and overflowing tables, and stalls on both sides.");
        if (mismatch_count == 0 && pending == 0)
        begin
            $display("word_frequency_counter_core_tb OK");
        end
        else
        begin
            if (pending != 0)
                $error("%0d expected results never arrived", pending);
            $display("word_frequency_counter_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/wfc_pkg.sv
hw/rtl/wfc_if.sv
hw/rtl/wfc_ctrl.sv
hw/rtl/wfc_datapath.sv
hw/rtl/word_frequency_counter_core.sv
sim/word_count_checker.sv
sim/word_frequency_counter_core_tb.sv
